// ===== sv/vcm_ramp_pkg.sv =====
// Shared types, register map, reset values and step-size helpers for the
// lens actuator position ramp stepper. No dependencies.
package vcm_ramp_pkg;

	// Widths of the position, the configuration registers, the internal compares and the bus.
	localparam int POS_BITS_DEF = 10;
	localparam int CFG_W        = 10;
	localparam int BYP_W        = 11;
	localparam int CMP_W        = 13;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 32;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] INF_RST    = CFG_W'(0);
	localparam logic [CFG_W-1:0] MACRO_RST  = CFG_W'(1023);
	localparam logic [CFG_W-1:0] NORMAL_RST = CFG_W'(100);
	localparam logic [CFG_W-1:0] PARK_RST   = CFG_W'(600);
	localparam logic [CFG_W-1:0] FINE_RST   = CFG_W'(2);
	localparam logic [BYP_W-1:0] BYPASS_RST = BYP_W'(700);

	// Register index, taken from the word address.
	typedef enum logic [2:0] {
		REG_INF    = 3'd0,
		REG_MACRO  = 3'd1,
		REG_NORMAL = 3'd2,
		REG_PARK   = 3'd3,
		REG_FINE   = 3'd4,
		REG_BYPASS = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_BUSY  = 2'd2
	} status_t;

	typedef enum logic {
		MODE_MOVE = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef struct packed {
		logic [CFG_W-1:0] inf_limit;
		logic [CFG_W-1:0] macro_limit;
		logic [CFG_W-1:0] normal_step;
		logic [CFG_W-1:0] park_step;
		logic [CFG_W-1:0] fine_step;
		logic [BYP_W-1:0] bypass_limit;
	} cfg_t;

	// Step size after the current phase ends; zero means the exact final write.
	function automatic logic [CFG_W-1:0] next_step(input logic [CFG_W-1:0] s,
			input logic [CFG_W-1:0] fine);
		return (fine != '0 && fine < s) ? fine : '0;
	endfunction

	// Step size that opens a ramp; a coarse step below the fine step is skipped.
	function automatic logic [CFG_W-1:0] first_step(input logic [CFG_W-1:0] coarse,
			input logic [CFG_W-1:0] fine);
		return (coarse != '0 && coarse >= fine) ? coarse : '0;
	endfunction

endpackage

// ===== sv/vcm_ramp_regs.sv =====
// APB-style configuration registers of the ramp stepper.
// Depends on vcm_ramp_pkg for the register map and reset values.
module vcm_ramp_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [vcm_ramp_pkg::ADDR_W-1:0] paddr,
	input  logic [vcm_ramp_pkg::DATA_W-1:0] pwdata,
	output logic [vcm_ramp_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output vcm_ramp_pkg::cfg_t              cfg
);
	import vcm_ramp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inf_limit    <= INF_RST;
			cfg_q.macro_limit  <= MACRO_RST;
			cfg_q.normal_step  <= NORMAL_RST;
			cfg_q.park_step    <= PARK_RST;
			cfg_q.fine_step    <= FINE_RST;
			cfg_q.bypass_limit <= BYPASS_RST;
		end else if (wr_en) begin
			case (idx)
				REG_INF:    cfg_q.inf_limit    <= pwdata[CFG_W-1:0];
				REG_MACRO:  cfg_q.macro_limit  <= pwdata[CFG_W-1:0];
				REG_NORMAL: cfg_q.normal_step  <= pwdata[CFG_W-1:0];
				REG_PARK:   cfg_q.park_step    <= pwdata[CFG_W-1:0];
				REG_FINE:   cfg_q.fine_step    <= pwdata[CFG_W-1:0];
				REG_BYPASS: cfg_q.bypass_limit <= pwdata[BYP_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		case (idx)
			REG_INF:    prdata = DATA_W'(cfg_q.inf_limit);
			REG_MACRO:  prdata = DATA_W'(cfg_q.macro_limit);
			REG_NORMAL: prdata = DATA_W'(cfg_q.normal_step);
			REG_PARK:   prdata = DATA_W'(cfg_q.park_step);
			REG_FINE:   prdata = DATA_W'(cfg_q.fine_step);
			REG_BYPASS: prdata = DATA_W'(cfg_q.bypass_limit);
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== sv/vcm_ramp_core.sv =====
// Position state and single-pass step logic of the ramp stepper.
// Depends on vcm_ramp_pkg for the configuration struct and step helpers.
module vcm_ramp_core #(
	parameter int POS_BITS = vcm_ramp_pkg::POS_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  vcm_ramp_pkg::cfg_t  cfg,
	input  logic                mode,
	input  logic [POS_BITS-1:0] target,
	input  logic                park,
	output logic                write_valid,
	output logic [5:0]          byte_high,
	output logic [7:0]          byte_low,
	output logic [POS_BITS-1:0] position,
	output logic                moving,
	output vcm_ramp_pkg::status_t status
);
	import vcm_ramp_pkg::*;

	logic [POS_BITS-1:0] cur_q, goal_q, cur_d, goal_d, diff;
	logic [CFG_W-1:0]    step_q, step_d, step_a, step_b;
	logic                up_q, up_d, ramp_q, ramp_d, wr;
	logic [CMP_W-1:0]    tgt_c, sum;
	status_t             st;

	// State moves only when the staged transaction is handed to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			goal_q <= '0;
			step_q <= '0;
			up_q   <= 1'b0;
			ramp_q <= 1'b0;
		end else if (fire) begin
			cur_q  <= cur_d;
			goal_q <= goal_d;
			step_q <= step_d;
			up_q   <= up_d;
			ramp_q <= ramp_d;
		end
	end

	// Move command handling and one ramp write per tick.
	always_comb begin
		cur_d  = cur_q;
		goal_d = goal_q;
		step_d = step_q;
		up_d   = up_q;
		ramp_d = ramp_q;
		wr     = 1'b0;
		st     = ST_OK;
		tgt_c  = CMP_W'(target);
		diff   = up_q ? goal_q - cur_q : cur_q - goal_q;
		step_a = (step_q != '0 && CMP_W'(diff) <= CMP_W'(step_q)) ?
			next_step(step_q, cfg.fine_step) : step_q;
		step_b = (step_a != '0 && CMP_W'(diff) <= CMP_W'(step_a)) ?
			next_step(step_a, cfg.fine_step) : step_a;
		sum    = up_q ? CMP_W'(cur_q) + CMP_W'(step_b) : CMP_W'(cur_q) - CMP_W'(step_b);
		if (mode_t'(mode) == MODE_MOVE) begin
			if (tgt_c > CMP_W'(cfg.macro_limit) || tgt_c < CMP_W'(cfg.inf_limit)) begin
				st = ST_RANGE;
			end else if (ramp_q) begin
				st = ST_BUSY;
			end else if (target != cur_q) begin
				up_d   = target > cur_q;
				goal_d = target;
				if (park) begin
					// An upward park move only records the goal.
					if (!up_d) begin
						step_d = first_step(cfg.park_step, cfg.fine_step);
						ramp_d = 1'b1;
					end
				end else if (tgt_c < CMP_W'(cfg.bypass_limit)) begin
					step_d = first_step(cfg.normal_step, cfg.fine_step);
					ramp_d = 1'b1;
				end else begin
					cur_d = target;
					wr    = 1'b1;
				end
			end
		end else if (ramp_q) begin
			step_d = step_b;
			wr     = 1'b1;
			if (step_b != '0) begin
				cur_d = sum[POS_BITS-1:0];
			end else begin
				cur_d  = goal_q;
				ramp_d = 1'b0;
			end
		end
	end

	// Result fields; a write is packed into two bus bytes.
	assign write_valid = wr;
	assign byte_high   = wr ? 6'(cur_d >> 4) : 6'd0;
	assign byte_low    = wr ? {cur_d[3:0], 4'b0000} : 8'd0;
	assign position    = cur_d;
	assign moving      = ramp_d;
	assign status      = st;

endmodule

// ===== sv/vcm_position_ramp_stepper.sv =====
// Top level of the lens actuator position ramp stepper: input stage, output
// register and assertions. Depends on vcm_ramp_pkg, vcm_ramp_regs, vcm_ramp_core.
//
// Usage: each input transaction on in_valid/in_ready is either a move command
// (mode 0) or a tick (mode 1). Every input transaction yields exactly one result
// transaction on out_valid/out_ready carrying write_valid, the two bus bytes,
// position, moving and status. A move command is range checked, rejected while
// a ramp runs, and either does nothing, arms a ramp or writes directly. Each
// tick during a ramp emits one position write.
// A transaction is held in the input stage and its result in the output register;
// a result is registered once the output register is free or drains.
// One transaction is accepted every cycle while the receiver does not stall, the
// rate set by the combinational step logic between the input stage and the output register.
// When the receiver stalls, the result holds in the output register and the
// input stage holds one more transaction, after which in_ready falls.
// Reset clears position, goal, step, direction and ramp state to zero, empties
// both stages and loads the configuration registers with their reset values.
// Configure over the APB-style port only while the block is idle; it is unchecked.
module vcm_position_ramp_stepper #(
	parameter int POS_BITS = vcm_ramp_pkg::POS_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [vcm_ramp_pkg::ADDR_W-1:0] paddr,
	input  logic [vcm_ramp_pkg::DATA_W-1:0] pwdata,
	output logic [vcm_ramp_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [POS_BITS-1:0]             target,
	input  logic                            park,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            write_valid,
	output logic [5:0]                      byte_high,
	output logic [7:0]                      byte_low,
	output logic [POS_BITS-1:0]             position,
	output logic                            moving,
	output logic [1:0]                      status
);
	import vcm_ramp_pkg::*;

	cfg_t                cfg;
	logic                valid_s1, mode_s1, park_s1, advance;
	logic [POS_BITS-1:0] target_s1;
	logic                out_valid_q, wr_q, moving_q;
	logic [5:0]          byte_high_q;
	logic [7:0]          byte_low_q;
	logic [POS_BITS-1:0] position_q;
	status_t             status_q;
	logic                wr_c, moving_c;
	logic [5:0]          byte_high_c;
	logic [7:0]          byte_low_c;
	logic [POS_BITS-1:0] position_c;
	status_t             status_c;

	vcm_ramp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vcm_ramp_core #(.POS_BITS(POS_BITS)) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.cfg         (cfg),
		.mode        (mode_s1),
		.target      (target_s1),
		.park        (park_s1),
		.write_valid (wr_c),
		.byte_high   (byte_high_c),
		.byte_low    (byte_low_c),
		.position    (position_c),
		.moving      (moving_c),
		.status      (status_c)
	);

	// The staged transaction moves on whenever the output register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1   <= mode;
			target_s1 <= target;
			park_s1   <= park;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wr_q        <= wr_c;
			byte_high_q <= byte_high_c;
			byte_low_q  <= byte_low_c;
			position_q  <= position_c;
			moving_q    <= moving_c;
			status_q    <= status_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign write_valid = wr_q;
	assign byte_high   = byte_high_q;
	assign byte_low    = byte_low_q;
	assign position    = position_q;
	assign moving      = moving_q;
	assign status      = status_q;

	// A written position always matches the packed bus bytes.
	a_bytes_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |->
			byte_high == 6'(position >> 4) && byte_low == {position[3:0], 4'b0000})
		else $error("bus bytes do not match written position");

	// Rejected commands never carry a write.
	a_reject_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !write_valid)
		else $error("rejected command produced a write");

	// A busy rejection can only happen while a ramp is in progress.
	a_busy_moving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BUSY |-> moving)
		else $error("busy status reported while idle");

	// The input side only stalls when the input stage is occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a held transaction");

endmodule
